// ===== rtl/core/msrml_pkg.sv =====
package msrml_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 32;
  localparam int INDEX_W  = 16;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] best_sum;
    logic [INDEX_W-1:0]      best_start;
    logic [INDEX_W-1:0]      best_end;
    logic                    too_short;
  } rsp_t;

endpackage

// ===== rtl/core/max_sum_run_min_length.sv =====
// Best contiguous run of at least MIN_RUN samples over a stream of signed samples.
//
// Request channel (req_valid, req_ready, req): one signed sample per request, with
// req.last marking the final sample of a stream. Response channel (rsp_valid,
// rsp_ready, rsp): one response per stream, carrying the best sum, the first and
// last index of the best run, and too_short when fewer than MIN_RUN samples came.
//
// Throughput is one request per cycle unless a held response stalls: each sample
// passes through a short chain of adders and compares between the request edge
// and the state registers. The response for a last request is valid in the
// cycle after that request is taken. Requests past MAX_ITEMS in one stream are
// taken but do not change the result; their last flag still closes the stream.
//
// The response sits in an output register. While the receiver stalls a held
// response, req_ready is low and no request of any kind is taken; req_ready is
// high whenever no response is held or the held one is taken in that cycle.
// Reset clears the stream state and the response valid flag; the block takes
// requests in the first cycle after reset is released.
module max_sum_run_min_length #(
  parameter int MIN_RUN   = 4,
  parameter int MAX_ITEMS = 65536
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  msrml_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output msrml_pkg::rsp_t rsp
);
  import msrml_pkg::*;

  // The count must hold MAX_ITEMS itself so it can stop there.
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  // Index arithmetic is done at least as wide as the output index.
  localparam int EXT_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  // Stream state. The window line is a shift line: tap 0 holds the newest sample
  // and the last tap holds the sample about to leave the window.
  logic signed [SAMPLE_W-1:0] window_line [MIN_RUN];
  logic signed [SUM_W-1:0]    window_total;
  logic signed [SUM_W-1:0]    suffix_total;
  logic [INDEX_W-1:0]         suffix_start;
  logic signed [SUM_W-1:0]    best_total;
  logic [INDEX_W-1:0]         best_first;
  logic [INDEX_W-1:0]         best_last;
  logic [CNT_W-1:0]           item_count;

  logic signed [SUM_W-1:0]    window_total_next;
  logic signed [SUM_W-1:0]    suffix_total_next;
  logic [INDEX_W-1:0]         suffix_start_next;
  logic signed [SUM_W-1:0]    best_total_next;
  logic [INDEX_W-1:0]         best_first_next;
  logic [INDEX_W-1:0]         best_last_next;
  logic [CNT_W-1:0]           item_count_next;

  logic                       req_fire;
  logic                       take;
  logic                       filling;
  logic signed [SUM_W-1:0]    oldest;
  logic signed [SUM_W-1:0]    newest;
  logic signed [SUM_W-1:0]    window_best;
  logic [INDEX_W-1:0]         window_first;
  logic signed [SUM_W-1:0]    both;
  logic [EXT_W-1:0]           n_ext;
  logic [EXT_W-1:0]           leave_idx;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;
  // A sample only counts while the stream is below its item limit.
  assign take      = req_fire && (item_count < CNT_W'(MAX_ITEMS));
  assign filling   = item_count < CNT_W'(MIN_RUN);

  assign newest    = SUM_W'(req.sample);
  assign oldest    = SUM_W'(window_line[MIN_RUN-1]);
  assign n_ext     = EXT_W'(item_count);
  assign leave_idx = n_ext - EXT_W'(MIN_RUN);

  always_comb begin
    window_total_next = window_total;
    suffix_total_next = suffix_total;
    suffix_start_next = suffix_start;
    best_total_next   = best_total;
    best_first_next   = best_first;
    best_last_next    = best_last;
    item_count_next   = item_count;
    window_best       = best_total;
    window_first      = best_first;
    both              = SUM_MIN;

    if (take) begin
      item_count_next = item_count + CNT_W'(1);
      // While filling, the oldest tap is still zero from reset. The window sum
      // never exceeds MIN_RUN full-scale samples, so it cannot overflow.
      window_total_next = window_total + newest - oldest;

      if (filling) begin
        if (item_count == CNT_W'(MIN_RUN - 1)) begin
          best_total_next = window_total_next;
          best_first_next = '0;
          best_last_next  = n_ext[INDEX_W-1:0];
        end
      end else begin
        // The suffix restarts at the leaving sample once its total went negative.
        if (suffix_total < 0) begin
          suffix_total_next = oldest;
          suffix_start_next = leave_idx[INDEX_W-1:0];
        end else begin
          suffix_total_next = sat_add(suffix_total, oldest);
        end

        if (window_total_next > best_total) begin
          window_best  = window_total_next;
          window_first = leave_idx[INDEX_W-1:0] + INDEX_W'(1);
        end
        best_total_next = window_best;
        best_first_next = window_first;
        if (window_total_next > best_total) begin
          best_last_next = n_ext[INDEX_W-1:0];
        end

        both = sat_add(window_total_next, suffix_total_next);
        if (both > window_best) begin
          best_total_next = both;
          best_first_next = suffix_start_next;
          best_last_next  = n_ext[INDEX_W-1:0];
        end
      end
    end
  end

  // A last request closes the stream and returns the state to its reset values.
  always_ff @(posedge clk) begin
    if (rst || (req_fire && req.last)) begin
      for (int i = 0; i < MIN_RUN; i++) begin
        window_line[i] <= '0;
      end
      window_total <= '0;
      suffix_total <= '0;
      suffix_start <= '0;
      best_total   <= '0;
      best_first   <= '0;
      best_last    <= '0;
      item_count   <= '0;
    end else begin
      if (take) begin
        window_line[0] <= req.sample;
        for (int i = 1; i < MIN_RUN; i++) begin
          window_line[i] <= window_line[i-1];
        end
      end
      window_total <= window_total_next;
      suffix_total <= suffix_total_next;
      suffix_start <= suffix_start_next;
      best_total   <= best_total_next;
      best_first   <= best_first_next;
      best_last    <= best_last_next;
      item_count   <= item_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire && req.last) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // The response payload is built from the state as it stands after the last sample.
  always_ff @(posedge clk) begin
    if (req_fire && req.last) begin
      if (item_count_next < CNT_W'(MIN_RUN)) begin
        rsp.best_sum   <= '0;
        rsp.best_start <= '0;
        rsp.best_end   <= '0;
        rsp.too_short  <= 1'b1;
      end else begin
        rsp.best_sum   <= best_total_next;
        rsp.best_start <= best_first_next;
        rsp.best_end   <= best_last_next;
        rsp.too_short  <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/msrml_chk.sv =====
module msrml_chk (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input msrml_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input msrml_pkg::rsp_t rsp
);
  import msrml_pkg::*;

  // A held response must not change until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Requests are only refused while a response is held back by the receiver.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request refused without a stalled response");

  // A last request produces a response in the next cycle.
  a_last_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.last |=> rsp_valid)
    else $error("no response after last request");

  // A new response only follows a last request.
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready && req.last))
    else $error("response without a last request");

  // A short stream reports all-zero fields.
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.too_short |->
      rsp.best_sum == '0 && rsp.best_start == '0 && rsp.best_end == '0)
    else $error("short stream with nonzero fields");

endmodule

bind max_sum_run_min_length msrml_chk u_msrml_chk (.*);

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msrml_pkg::*;

  // The block is built with its default sizes; the predictor below uses the same.
  localparam int MIN_RUN   = 4;
  localparam int MAX_ITEMS = 65536;

  // The run stops here no matter what.
  localparam int CYCLE_LIMIT = 1000000;

  // Random streams are drawn until this many samples have been queued.
  localparam int RANDOM_SAMPLES = 1320;

  // Once no more than this many requests are left to offer, both sides stop
  // idling so the end of the run is back-to-back traffic.
  localparam int QUIET_SAMPLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b1;
  rsp_t rsp;

  max_sum_run_min_length #(
    .MIN_RUN  (MIN_RUN),
    .MAX_ITEMS(MAX_ITEMS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, filled once by the initial block below, and
  // the best-run results that accepted last requests are known to produce.
  req_t sample_q[$];
  rsp_t best_run_q[$];

  int cycle_cnt  = 0;
  int fail_cnt   = 0;
  int quiet_tail = 0;
  int idle_left  = 0;
  int stall_left = 0;

  // Shadow of the stream state. Samples and sums are kept sign-extended to the
  // sum width so that every compare below is a signed compare.
  logic signed [SUM_W-1:0] win_line [MIN_RUN];
  logic signed [SUM_W-1:0] win_sum;
  logic signed [SUM_W-1:0] tail_sum;
  logic signed [SUM_W-1:0] top_sum;
  int                      tail_first;
  int                      top_first;
  int                      top_last;
  int                      run_len;

  function automatic void clear_stream();
    for (int i = 0; i < MIN_RUN; i++) begin
      win_line[i] = '0;
    end
    win_sum    = '0;
    tail_sum   = '0;
    top_sum    = '0;
    tail_first = 0;
    top_first  = 0;
    top_last   = 0;
    run_len    = 0;
  endfunction

  // Adds two sums in one extra bit and clamps the result to the signed range.
  function automatic logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] a,
                                                       logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = $signed({a[SUM_W-1], a}) + $signed({b[SUM_W-1], b});
    if (s > $signed({1'b0, SUM_MAX})) begin
      return SUM_MAX;
    end
    if (s < $signed({1'b1, SUM_MIN})) begin
      return SUM_MIN;
    end
    return s[SUM_W-1:0];
  endfunction

  // Advances the shadow state by one accepted request. Once the stream has
  // counted MAX_ITEMS samples, further samples leave the state alone, but a last
  // flag still closes the stream and yields its result.
  function automatic void track_sample(req_t r);
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] old;
    logic signed [SUM_W-1:0] both;
    rsp_t                    res;
    int                      slot;
    if (run_len < MAX_ITEMS) begin
      x    = {{(SUM_W-SAMPLE_W){r.sample[SAMPLE_W-1]}}, r.sample};
      slot = run_len % MIN_RUN;
      if (run_len < MIN_RUN) begin
        // Filling the first window: its sum is the first candidate.
        win_sum        = clamp_add(win_sum, x);
        win_line[slot] = x;
        if (run_len == MIN_RUN - 1) begin
          top_sum   = win_sum;
          top_first = 0;
          top_last  = run_len;
        end
      end else begin
        // The sample dropping out of the window joins the suffix, which starts
        // over at that sample whenever its total has gone negative.
        old = win_line[slot];
        if (tail_sum < 0) begin
          tail_sum   = old;
          tail_first = run_len - MIN_RUN;
        end else begin
          tail_sum = clamp_add(tail_sum, old);
        end
        win_sum        = clamp_add(clamp_add(win_sum, x), -old);
        win_line[slot] = x;
        // Strictly greater only, so on a tie the earlier run is kept.
        if (win_sum > top_sum) begin
          top_sum   = win_sum;
          top_first = run_len - MIN_RUN + 1;
          top_last  = run_len;
        end
        both = clamp_add(win_sum, tail_sum);
        if (both > top_sum) begin
          top_sum   = both;
          top_first = tail_first;
          top_last  = run_len;
        end
      end
      run_len++;
    end
    if (r.last) begin
      res = '0;
      if (run_len < MIN_RUN) begin
        res.too_short = 1'b1;
      end else begin
        res.best_sum   = top_sum;
        res.best_start = top_first[INDEX_W-1:0];
        res.best_end   = top_last[INDEX_W-1:0];
      end
      best_run_q.push_back(res);
      clear_stream();
    end
  endfunction

  // Idling is off for the final stretch of requests, and for one stretch out of
  // every four along the way so the block also sees back-to-back traffic.
  function automatic bit idling_on();
    return sample_q.size() > quiet_tail && ((cycle_cnt / 400) % 4) != 3;
  endfunction

  function automatic void queue_sample(logic [SAMPLE_W-1:0] s, logic fin);
    req_t r;
    r.sample = s;
    r.last   = fin;
    sample_q.push_back(r);
  endfunction

  // Driver. An accepted request goes to the predictor at the edge where it is
  // taken. A new request is only offered once the previous one is gone, so
  // valid never drops while a request is waiting.
  always @(posedge clk) begin
    logic nxt_valid;
    req_t nxt_req;
    if (rst) begin
      req_valid <= 1'b0;
      idle_left = 0;
      clear_stream();
    end else begin
      nxt_valid = req_valid;
      nxt_req   = req;
      if (req_valid && req_ready) begin
        track_sample(req);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (sample_q.size() != 0) begin
          if (idling_on() && $urandom_range(0, 5) == 0) begin
            // Start an idle stretch of random length.
            idle_left = $urandom_range(0, 8);
          end else begin
            nxt_req   = sample_q.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
      req_valid <= nxt_valid;
      req       <= nxt_req;
    end
  end

  // Monitor. Each response taken is checked against the oldest pending best-run
  // result; the receiver stalls in bursts to back the block up.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (best_run_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("unexpected response at cycle %0d: sum %0d start %0d end %0d short %0b",
                     cycle_cnt, rsp.best_sum, rsp.best_start, rsp.best_end, rsp.too_short);
          end
        end else begin
          want = best_run_q.pop_front();
          if (rsp.best_sum !== want.best_sum || rsp.best_start !== want.best_start ||
              rsp.best_end !== want.best_end || rsp.too_short !== want.too_short) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("mismatch at cycle %0d: expected sum %0d start %0d end %0d short %0b,",
                       cycle_cnt, want.best_sum, want.best_start, want.best_end,
                       want.too_short);
              $display("  got sum %0d start %0d end %0d short %0b",
                       rsp.best_sum, rsp.best_start, rsp.best_end, rsp.too_short);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog on a hung block or a lost response.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int                  rand_samples;
    int                  len;
    int                  mode;
    logic [SAMPLE_W-1:0] s;

    // Directed streams. A lone sample and a stream of three are both too short.
    queue_sample(16'h7FFF, 1'b1);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'hFFFF, 1'b1);
    // Exactly one window, all at the top of the range.
    for (int i = 0; i < MIN_RUN; i++) begin
      queue_sample(16'h7FFF, i == MIN_RUN - 1);
    end
    // All at the bottom of the range: every window ties, so the first one wins.
    for (int i = 0; i < MIN_RUN + 1; i++) begin
      queue_sample(16'h8000, i == MIN_RUN);
    end
    // The suffix first picks up a positive sample, turns negative and starts
    // over, and finally extends the best run back past the window.
    queue_sample(16'd3, 1'b0);
    queue_sample(-16'sd8, 1'b0);
    queue_sample(16'd2, 1'b0);
    queue_sample(16'd2, 1'b0);
    queue_sample(16'd2, 1'b0);
    queue_sample(16'd2, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'd9, 1'b0);
    queue_sample(16'd9, 1'b0);
    queue_sample(16'd4, 1'b1);

    // Random streams, mostly short, in a few value patterns: full range, small
    // values around zero, only the corner values, and mostly small positive with
    // deep negative dips that force the suffix to restart.
    rand_samples = 0;
    while (rand_samples < RANDOM_SAMPLES) begin
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: begin
            s = SAMPLE_W'($urandom);
          end
          1: begin
            s = SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
          end
          2: begin
            case ($urandom_range(0, 4))
              0:       s = 16'h7FFF;
              1:       s = 16'h8000;
              2:       s = 16'h0000;
              3:       s = 16'hFFFF;
              default: s = 16'h0001;
            endcase
          end
          default: begin
            s = ($urandom_range(0, 3) != 0) ? SAMPLE_W'($urandom_range(0, 2000))
                                            : SAMPLE_W'(-int'($urandom_range(1000, 32768)));
          end
        endcase
        queue_sample(s, k == len - 1);
      end
      rand_samples += len;
    end

    quiet_tail = QUIET_SAMPLES;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every result to come back, then
    // give the block time to show any response that should not be there.
    while (sample_q.size() != 0 || req_valid || best_run_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (best_run_q.size() != 0) begin
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
